@@ src/dtfp_pkg.sv @@
// Shared types, constants and the helper function of the decimal text to fixed-point parser.
`timescale 1ns / 1ps

package dtfp_pkg;

	// Number of weighted fraction digits
	localparam int FRAC_DIGITS = 4;

	// One unit expressed in ticks
	localparam logic [63:0] SCALE = 64'(10 ** FRAC_DIGITS);

	// Largest magnitude a result may take
	localparam logic [63:0] MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

	// Largest whole part, already scaled by SCALE
	localparam logic [63:0] LIMIT_SCALED = (MAX_MAG / SCALE) * SCALE;

	// Scaled whole part always stays below 2^63
	localparam int SCALED_W = 63;

	// Width for scaled value times ten plus one scaled digit
	localparam int WIDE_W = SCALED_W + 4;

	// Fraction accumulator, wide enough for SCALE itself (fraction plus round)
	localparam int FRAC_W = $clog2(SCALE + 64'd1);

	// Fraction digit counter saturates at FRAC_DIGITS + 1
	localparam int CNT_W = $clog2(FRAC_DIGITS + 2);

	// ASCII codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_DIGITS = 2'd1,
		ST_BAD_CHAR  = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// Parser state captured at the end of a string
	typedef struct packed {
		logic                negative;
		logic                seen_digit;
		logic                round_up;
		status_t             error_code;
		logic [SCALED_W-1:0] scaled;
		logic [FRAC_W-1:0]   fraction;
	} snap_t;

	// Weight of one fraction digit at the given position
	function automatic logic [FRAC_W-1:0] frac_term(input logic [3:0] digit,
		input logic [CNT_W-1:0] pos);
		logic [FRAC_W-1:0] term;
		term = '0;
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			if (pos == CNT_W'(i)) begin
				term = FRAC_W'(32'(digit) * 32'(10 ** (FRAC_DIGITS - 1 - i)));
			end
		end
		return term;
	endfunction

endpackage

@@ src/dtfp_parse.sv @@
// Input register and per-character parser state update.
`timescale 1ns / 1ps

module dtfp_parse
	import dtfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  logic [7:0] in_char,
	input  logic       in_has_char,
	input  logic       in_last,
	output logic       snap_valid_s2,
	output snap_t      snap_s2
);

	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                has_char_s1;
	logic                last_s1;

	logic                at_start_q;
	logic                negative_q;
	logic                in_frac_q;
	logic                seen_q;
	logic [CNT_W-1:0]    count_q;
	logic                round_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [FRAC_W-1:0]   frac_q;
	status_t             err_q;

	logic                at_start_d;
	logic                negative_d;
	logic                in_frac_d;
	logic                seen_d;
	logic [CNT_W-1:0]    count_d;
	logic                round_d;
	logic [SCALED_W-1:0] scaled_d;
	logic [FRAC_W-1:0]   frac_d;
	status_t             err_d;

	logic                is_digit;
	logic [3:0]          digit;
	logic [WIDE_W-1:0]   wide_next;

	// Capture one character transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			char_s1     <= in_char;
			has_char_s1 <= in_has_char;
			last_s1     <= in_last;
		end
	end

	// Decode the character and build the whole part times ten plus digit
	assign is_digit  = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign digit     = char_s1[3:0];
	assign wide_next = (WIDE_W'(scaled_q) << 3) + (WIDE_W'(scaled_q) << 1)
		+ WIDE_W'(digit) * WIDE_W'(SCALE);

	// Next parser state for one character
	always_comb begin
		at_start_d = at_start_q;
		negative_d = negative_q;
		in_frac_d  = in_frac_q;
		seen_d     = seen_q;
		count_d    = count_q;
		round_d    = round_q;
		scaled_d   = scaled_q;
		frac_d     = frac_q;
		err_d      = err_q;
		if (has_char_s1) begin
			at_start_d = 1'b0;
			if (at_start_q && (char_s1 == CH_PLUS || char_s1 == CH_MINUS)) begin
				negative_d = (char_s1 == CH_MINUS);
			end else if (char_s1 == CH_DOT) begin
				if (in_frac_q) begin
					err_d = ST_BAD_CHAR;
				end else begin
					in_frac_d = 1'b1;
				end
			end else if (!is_digit) begin
				err_d = ST_BAD_CHAR;
			end else begin
				seen_d = 1'b1;
				if (in_frac_q) begin
					if (count_q < CNT_W'(FRAC_DIGITS)) begin
						frac_d = frac_q + frac_term(digit, count_q);
					end else if (count_q == CNT_W'(FRAC_DIGITS)) begin
						round_d = (char_s1 >= CH_FIVE);
					end
					if (count_q <= CNT_W'(FRAC_DIGITS)) begin
						count_d = count_q + CNT_W'(1);
					end
				end else if (wide_next > WIDE_W'(LIMIT_SCALED)) begin
					if (err_q == ST_OK) begin
						err_d = ST_OVERFLOW;
					end
				end else begin
					scaled_d = wide_next[SCALED_W-1:0];
				end
			end
		end
	end

	// Advance parser state; return to start state after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			negative_q <= 1'b0;
			in_frac_q  <= 1'b0;
			seen_q     <= 1'b0;
			count_q    <= '0;
			round_q    <= 1'b0;
			scaled_q   <= '0;
			frac_q     <= '0;
			err_q      <= ST_OK;
		end else if (en && valid_s1) begin
			if (last_s1) begin
				at_start_q <= 1'b1;
				negative_q <= 1'b0;
				in_frac_q  <= 1'b0;
				seen_q     <= 1'b0;
				count_q    <= '0;
				round_q    <= 1'b0;
				scaled_q   <= '0;
				frac_q     <= '0;
				err_q      <= ST_OK;
			end else begin
				at_start_q <= at_start_d;
				negative_q <= negative_d;
				in_frac_q  <= in_frac_d;
				seen_q     <= seen_d;
				count_q    <= count_d;
				round_q    <= round_d;
				scaled_q   <= scaled_d;
				frac_q     <= frac_d;
				err_q      <= err_d;
			end
		end
	end

	// Hold the finished string state for the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (en) begin
			snap_valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			snap_s2.negative   <= negative_d;
			snap_s2.seen_digit <= seen_d;
			snap_s2.round_up   <= round_d;
			snap_s2.error_code <= err_d;
			snap_s2.scaled     <= scaled_d;
			snap_s2.fraction   <= frac_d;
		end
	end

endmodule

@@ src/dtfp_result.sv @@
// Final combine of whole and fraction parts, sign, status and output register.
`timescale 1ns / 1ps

module dtfp_result
	import dtfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        snap_valid,
	input  snap_t       snap,
	output logic        out_valid,
	output logic [63:0] out_ticks,
	output status_t     out_status
);

	logic [FRAC_W-1:0] tail;
	logic [63:0]       mag;
	logic [63:0]       neg_mag;
	logic              mag_ovf;
	logic [63:0]       ticks_d;
	status_t           status_d;

	// Add fraction and rounding; negate as one three-input add
	assign tail    = snap.fraction + FRAC_W'(snap.round_up);
	assign mag     = {1'b0, snap.scaled} + 64'(tail);
	assign neg_mag = ~{1'b0, snap.scaled} + ~64'(tail) + 64'd2;
	assign mag_ovf = mag[63];

	// Pick status by priority and zero the value on any error
	always_comb begin
		ticks_d = '0;
		if (snap.error_code == ST_BAD_CHAR) begin
			status_d = ST_BAD_CHAR;
		end else if (!snap.seen_digit) begin
			status_d = ST_NO_DIGITS;
		end else if (snap.error_code == ST_OVERFLOW || mag_ovf) begin
			status_d = ST_OVERFLOW;
		end else begin
			status_d = ST_OK;
			ticks_d  = snap.negative ? neg_mag : mag;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ticks  <= ticks_d;
			out_status <= status_d;
		end
	end

endmodule

@@ src/decimal_text_to_fixed_point.sv @@
// Top level of the decimal text to fixed-point parser.
`timescale 1ns / 1ps

// Parses an ASCII decimal price, one character per transfer, into a signed
// count of ticks of 1/10000 unit. An optional '+' or '-' may come first, then
// integer digits and at most one '.', then fraction digits; the fifth fraction
// digit rounds half away from zero and later ones are only checked. The
// transfer with tlast set ends the string (tuser low marks a bare end marker
// with no character) and produces exactly one result transfer: ticks in
// tdata and a status in tuser (0 ok, 1 no digits, 2 bad character or second
// dot, 3 overflow beyond 2^63 - 1, with ticks zero on any error). The block
// takes one character every cycle; a result passes from its last character
// through input register, snapshot register and output register.
// The whole pipeline holds while a result waits and tready is low.
module decimal_text_to_fixed_point
	import dtfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] character
	input  logic        s_tuser,   // [0] has_char
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] ticks
	output logic [1:0]  m_tuser    // [1:0] status
);

	logic    en;
	logic    snap_valid_s2;
	snap_t   snap_s2;
	status_t status;

	// Advance all stages whenever the output register can take a value
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tuser  = status;

	dtfp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_tvalid),
		.in_char       (s_tdata),
		.in_has_char   (s_tuser),
		.in_last       (s_tlast),
		.snap_valid_s2 (snap_valid_s2),
		.snap_s2       (snap_s2)
	);

	dtfp_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.snap_valid (snap_valid_s2),
		.snap       (snap_s2),
		.out_valid  (m_tvalid),
		.out_ticks  (m_tdata),
		.out_status (status)
	);

endmodule
